// ===== rtl/efd_pkg.sv =====
// ----------------------------------------------------------------------------
// efd_pkg: shared types, constants and tables of the EEG frame deframer
// Frame geometry tables indexed by device generation and speed mode, result
// encodings and the configuration register map.
// ----------------------------------------------------------------------------
package efd_pkg;

  localparam logic [31:0] SYNC_WORD       = 32'hFFFF_FF00;
  localparam int          MAX_FRAME_WORDS = 1024;
  localparam int          SPEED_MODES     = 10;
  localparam int          DIST_W          = $clog2(MAX_FRAME_WORDS + 1);

  // configuration register map
  localparam int          CFG_IDX_W   = 2;
  localparam int          CFG_DATA_W  = 9;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_EX  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQ_CNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIVER = 2'd2;

  typedef enum logic [1:0] {
    PH_HUNT_FIRST  = 2'd0,
    PH_HUNT_SECOND = 2'd1,
    PH_LOCKED      = 2'd2
  } efd_phase_e;

  typedef enum logic [1:0] {
    KIND_STATUS = 2'd0,
    KIND_SAMPLE = 2'd1,
    KIND_ERROR  = 2'd2
  } efd_kind_e;

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TYPE      = 2'd1,
    ERR_SPEED     = 2'd2,
    ERR_BAD_SPEED = 2'd3
  } efd_err_e;

  typedef struct packed {
    logic       use_ex;
    logic [8:0] req_cnt;
    logic       deliver;
  } efd_cfg_t;

  typedef struct packed {
    logic [9:0] frame_len;
    logic [9:0] ex_start;
    logic [3:0] ex_cnt;
    logic [8:0] elec_out;
    logic [9:0] last_pos;
  } efd_layout_t;

  typedef struct packed {
    efd_kind_e          kind;
    logic [8:0]         channel_number;
    logic signed [31:0] sample_value;
    logic [15:0]        trigger_bits;
    logic               epoch_started;
    logic               cms_in_range;
    logic               battery_low;
    logic               mark_two;
    logic [2:0]         speed_mode;
    efd_err_e           error_code;
    logic               frame_end;
  } efd_result_t;

  // words per frame
  function automatic logic [9:0] frame_len_f(input logic mk, input logic [2:0] sp);
    logic [9:0] v;
    unique case ({mk, sp})
      4'h0: v = 10'd258;  4'h1: v = 10'd130;  4'h2: v = 10'd66;   4'h3: v = 10'd34;
      4'h4: v = 10'd258;  4'h5: v = 10'd130;  4'h6: v = 10'd66;   4'h7: v = 10'd34;
      4'h8: v = 10'd610;  4'h9: v = 10'd610;  4'hA: v = 10'd610;  4'hB: v = 10'd610;
      4'hC: v = 10'd282;  4'hD: v = 10'd154;  4'hE: v = 10'd90;   4'hF: v = 10'd58;
      default: v = '0;
    endcase
    return v;
  endfunction

  // electrode words per frame
  function automatic logic [8:0] elec_cnt_f(input logic mk, input logic [2:0] sp);
    logic [8:0] v;
    unique case ({mk, sp})
      4'h0: v = 9'd256;  4'h1: v = 9'd128;  4'h2: v = 9'd256;  4'h3: v = 9'd34;
      4'h4: v = 9'd232;  4'h5: v = 9'd104;  4'h6: v = 9'd40;   4'h7: v = 9'd8;
      4'h8: v = 9'd256;  4'h9: v = 9'd128;  4'hA: v = 9'd256;  4'hB: v = 9'd128;
      4'hC: v = 9'd256;  4'hD: v = 9'd128;  4'hE: v = 9'd64;   4'hF: v = 9'd32;
      default: v = '0;
    endcase
    return v;
  endfunction

  // external words per frame
  function automatic logic [3:0] ex_cnt_f(input logic mk, input logic [2:0] sp);
    logic [3:0] v;
    if (!mk && !sp[2]) begin
      v = 4'd0;
    end else begin
      v = 4'd8;
    end
    return v;
  endfunction

endpackage

// ===== rtl/efd_in_if.sv =====
// ----------------------------------------------------------------------------
// efd_in_if: input stream channel
// Valid/ready channel carrying one raw amplifier stream word per transaction.
// ----------------------------------------------------------------------------
interface efd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] stream_word;

  modport source (output valid, output stream_word, input ready);
  modport sink   (input valid, input stream_word, output ready);
endinterface

// ===== rtl/efd_out_if.sv =====
// ----------------------------------------------------------------------------
// efd_out_if: result channel
// Valid/ready channel carrying one status, sample or error result.
// ----------------------------------------------------------------------------
interface efd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         result_kind;
  logic [8:0]         channel_number;
  logic signed [31:0] sample_value;
  logic [15:0]        trigger_bits;
  logic               epoch_started;
  logic               cms_in_range;
  logic               battery_low;
  logic               mark_two;
  logic [2:0]         speed_mode;
  logic [1:0]         error_code;
  logic               frame_end;

  modport source (
    output valid, input ready,
    output result_kind, output channel_number, output sample_value,
    output trigger_bits, output epoch_started, output cms_in_range,
    output battery_low, output mark_two, output speed_mode,
    output error_code, output frame_end
  );
  modport sink (
    input valid, output ready,
    input result_kind, input channel_number, input sample_value,
    input trigger_bits, input epoch_started, input cms_in_range,
    input battery_low, input mark_two, input speed_mode,
    input error_code, input frame_end
  );
endinterface

// ===== rtl/efd_layout.sv =====
// ----------------------------------------------------------------------------
// efd_layout: frame layout decode
// Derives frame length, electrode output count, EX window and the position
// of the last delivered word from the configuration and the locked mode.
// ----------------------------------------------------------------------------
module efd_layout
  import efd_pkg::*;
(
  input  efd_cfg_t    cfg_i,
  input  logic        mark_two_i,
  input  logic [2:0]  speed_mode_i,
  output efd_layout_t layout_o
);

  logic [9:0] frame_len;
  logic [8:0] elec;
  logic [8:0] ex_num;
  logic [8:0] elec_req;
  logic [9:0] room;
  logic [8:0] elec_out0;
  logic [8:0] elec_out;
  logic [8:0] want;
  logic [9:0] ex_start;
  logic [9:0] ex_room;
  logic [3:0] ex_cnt;
  logic [9:0] last_pos;

  always_comb begin
    frame_len = frame_len_f(mark_two_i, speed_mode_i);
    elec      = elec_cnt_f(mark_two_i, speed_mode_i);
    ex_num    = cfg_i.use_ex ? {5'd0, ex_cnt_f(mark_two_i, speed_mode_i)} : 9'd0;

    // electrode share of the request, EX share comes off the top
    elec_req  = (cfg_i.req_cnt > ex_num) ? cfg_i.req_cnt - ex_num : 9'd0;
    room      = frame_len - 10'd2;
    elec_out0 = ({1'b0, elec_req} < room) ? elec_req : room[8:0];
    elec_out  = (cfg_i.use_ex && (elec < elec_out0)) ? elec : elec_out0;

    want      = (cfg_i.req_cnt > ex_num) ? ex_num : cfg_i.req_cnt;
    ex_start  = {1'b0, elec} + 10'd2;
    ex_room   = frame_len - ex_start;
    ex_cnt    = 4'd0;
    if (cfg_i.use_ex && (ex_start < frame_len)) begin
      ex_cnt = ({1'b0, want} < ex_room) ? want[3:0] : ex_room[3:0];
    end

    if (!cfg_i.deliver) begin
      last_pos = 10'd1;
    end else if (ex_cnt != 4'd0) begin
      last_pos = ex_start + {6'd0, ex_cnt} - 10'd1;
    end else if (elec_out != 9'd0) begin
      last_pos = {1'b0, elec_out} + 10'd1;
    end else begin
      last_pos = 10'd1;
    end

    layout_o.frame_len = frame_len;
    layout_o.ex_start  = ex_start;
    layout_o.ex_cnt    = ex_cnt;
    layout_o.elec_out  = elec_out;
    layout_o.last_pos  = last_pos;
  end

endmodule

// ===== rtl/efd_core.sv =====
// ----------------------------------------------------------------------------
// efd_core: sync hunt and frame walker
// Holds the sync and frame state, decodes one stream word per advance and
// produces at most one result for it.
// ----------------------------------------------------------------------------
module efd_core
  import efd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [31:0] word_i,
  input  efd_cfg_t    cfg_i,
  output logic        res_valid_o,
  output efd_result_t res_o
);

  efd_phase_e  phase_q, phase_d;
  logic [DIST_W-1:0] dist_q, dist_d;
  logic [31:8] fsw_q, fsw_d;
  logic [8:0]  chan_cnt_q, chan_cnt_d;
  logic [9:0]  pos_q, pos_d;
  logic [2:0]  init_sp_q, init_sp_d;
  logic        init_mk_q, init_mk_d;

  efd_layout_t layout;

  logic [DIST_W-1:0] dist_inc;
  logic [9:0]  cc_raw;
  logic [8:0]  elec_lock;
  logic [2:0]  sp_w;
  logic        mk_w;
  logic [2:0]  sp_f;
  logic        mk_f;
  logic [9:0]  pos_inc;
  logic [8:0]  idx;
  logic [9:0]  ex_off;
  logic        is_sync;

  efd_layout u_layout (
    .cfg_i       (cfg_i),
    .mark_two_i  (init_mk_q),
    .speed_mode_i(init_sp_q),
    .layout_o    (layout)
  );

  function automatic efd_result_t status_f(input logic [31:8] w, input efd_kind_e kind,
                                           input efd_err_e err, input logic fend);
    efd_result_t r;
    r.kind           = kind;
    r.channel_number = '0;
    r.sample_value   = '0;
    r.trigger_bits   = w[23:8];
    r.epoch_started  = w[24];
    r.cms_in_range   = ~w[28];
    r.battery_low    = w[30];
    r.mark_two       = w[31];
    r.speed_mode     = w[27:25];
    r.error_code     = err;
    r.frame_end      = fend;
    return r;
  endfunction

  always_comb begin
    phase_d    = phase_q;
    dist_d     = dist_q;
    fsw_d      = fsw_q;
    chan_cnt_d = chan_cnt_q;
    pos_d      = pos_q;
    init_sp_d  = init_sp_q;
    init_mk_d  = init_mk_q;

    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.kind       = KIND_STATUS;
    res_o.error_code = ERR_NONE;

    is_sync   = (word_i == SYNC_WORD);
    dist_inc  = dist_q + DIST_W'(1);
    cc_raw    = dist_inc[9:0] - 10'd2;
    sp_f      = fsw_q[27:25];
    mk_f      = fsw_q[31];
    elec_lock = elec_cnt_f(mk_f, sp_f);
    sp_w      = word_i[27:25];
    mk_w      = word_i[31];
    pos_inc   = pos_q + 10'd1;
    idx       = pos_q[8:0] - 9'd2;
    ex_off    = pos_q - layout.ex_start;

    unique case (phase_q)
      PH_HUNT_FIRST: begin
        if (is_sync) begin
          phase_d = PH_HUNT_SECOND;
          dist_d  = '0;
        end
      end

      PH_HUNT_SECOND: begin
        dist_d = dist_inc;
        if (!is_sync) begin
          if (dist_inc == DIST_W'(1)) begin
            fsw_d = word_i[31:8];
          end
          if (dist_inc >= DIST_W'(MAX_FRAME_WORDS)) begin
            phase_d = PH_HUNT_FIRST;
          end
        end else if (dist_inc < DIST_W'(2)) begin
          // back-to-back sync restarts the distance count
          dist_d = '0;
        end else if ({1'b0, sp_f} >= 4'(SPEED_MODES)) begin
          phase_d     = PH_HUNT_FIRST;
          res_valid_o = 1'b1;
          res_o       = status_f(fsw_q, KIND_ERROR, ERR_BAD_SPEED, 1'b1);
        end else begin
          init_sp_d  = sp_f;
          init_mk_d  = mk_f;
          chan_cnt_d = (cc_raw < {1'b0, elec_lock}) ? cc_raw[8:0] : elec_lock;
          pos_d      = '0;
          phase_d    = PH_LOCKED;
        end
      end

      PH_LOCKED: begin
        pos_d = (pos_inc >= layout.frame_len) ? 10'd0 : pos_inc;
        if (pos_q == 10'd1) begin
          res_valid_o = 1'b1;
          if (mk_w != init_mk_q) begin
            phase_d = PH_HUNT_FIRST;
            pos_d   = '0;
            res_o   = status_f(word_i[31:8], KIND_ERROR, ERR_TYPE, 1'b1);
          end else if (sp_w != init_sp_q) begin
            phase_d = PH_HUNT_FIRST;
            pos_d   = '0;
            res_o   = status_f(word_i[31:8], KIND_ERROR, ERR_SPEED, 1'b1);
          end else if ({1'b0, sp_w} >= 4'(SPEED_MODES)) begin
            phase_d = PH_HUNT_FIRST;
            pos_d   = '0;
            res_o   = status_f(word_i[31:8], KIND_ERROR, ERR_BAD_SPEED, 1'b1);
          end else begin
            res_o = status_f(word_i[31:8], KIND_STATUS, ERR_NONE,
                             layout.last_pos == 10'd1);
          end
        end else if (pos_q >= 10'd2 && cfg_i.deliver) begin
          if (pos_q < {1'b0, layout.elec_out} + 10'd2) begin
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_SAMPLE;
            res_o.channel_number = idx;
            // electrodes beyond the measured channel count are zero padded
            res_o.sample_value   = (idx < chan_cnt_q) ? word_i : '0;
            res_o.frame_end      = (pos_q == layout.last_pos);
          end else if (layout.ex_cnt != 4'd0 && pos_q >= layout.ex_start &&
                       pos_q < layout.ex_start + {6'd0, layout.ex_cnt}) begin
            res_valid_o          = 1'b1;
            res_o.kind           = KIND_SAMPLE;
            res_o.channel_number = layout.elec_out + ex_off[8:0];
            res_o.sample_value   = word_i;
            res_o.frame_end      = (pos_q == layout.last_pos);
          end
        end
      end

      default: begin
        phase_d = PH_HUNT_FIRST;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT_FIRST;
      dist_q     <= '0;
      chan_cnt_q <= '0;
      pos_q      <= '0;
      init_sp_q  <= '0;
      init_mk_q  <= 1'b0;
    end else if (adv_i) begin
      phase_q    <= phase_d;
      dist_q     <= dist_d;
      chan_cnt_q <= chan_cnt_d;
      pos_q      <= pos_d;
      init_sp_q  <= init_sp_d;
      init_mk_q  <= init_mk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      fsw_q <= fsw_d;
    end
  end

endmodule

// ===== rtl/eeg_frame_deframer_top.sv =====
// ----------------------------------------------------------------------------
// eeg_frame_deframer_top: EEG amplifier stream deframer
// Input word register, frame decode core and result register with
// valid/ready handshake on both sides plus a configuration write port.
// ----------------------------------------------------------------------------
// One stream word is taken per cycle while the result register is not stalled:
// a word sits in the input register, is decoded by the core against the sync
// and frame state, and its result (if any) lands in the result register,
// which is the only thing that can stall the input. After reset the block
// hunts for two sync words, locks to the frame layout given by the first
// status word, then emits a status transaction per frame followed by the
// requested channel samples; frame_end marks the last one. Configuration
// writes take effect on the next word decoded.
module eeg_frame_deframer_top
  import efd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  efd_in_if.sink                in_ch,
  efd_out_if.source             out_ch,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  efd_cfg_t    cfg_q;
  logic        in_vld_q;
  logic [31:0] word_q;
  logic        out_vld_q;
  efd_result_t res_q;

  logic        adv;
  logic        res_valid;
  efd_result_t res;

  // the input stage moves on whenever it holds a word and the result register can take a value
  assign adv         = in_vld_q & (~out_vld_q | out_ch.ready);
  assign in_ch.ready = ~in_vld_q | adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.use_ex  <= 1'b0;
      cfg_q.req_cnt <= '0;
      cfg_q.deliver <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_USE_EX:  cfg_q.use_ex  <= cfg_data_i[0];
        CFG_REQ_CNT: cfg_q.req_cnt <= cfg_data_i[8:0];
        CFG_DELIVER: cfg_q.deliver <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        in_vld_q <= in_ch.valid;
      end
      if (adv) begin
        out_vld_q <= res_valid;
      end else if (out_ch.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ch.valid && in_ch.ready) begin
      word_q <= in_ch.stream_word;
    end
    if (adv && res_valid) begin
      res_q <= res;
    end
  end

  efd_core u_core (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .word_i     (word_q),
    .cfg_i      (cfg_q),
    .res_valid_o(res_valid),
    .res_o      (res)
  );

  assign out_ch.valid          = out_vld_q;
  assign out_ch.result_kind    = res_q.kind;
  assign out_ch.channel_number = res_q.channel_number;
  assign out_ch.sample_value   = res_q.sample_value;
  assign out_ch.trigger_bits   = res_q.trigger_bits;
  assign out_ch.epoch_started  = res_q.epoch_started;
  assign out_ch.cms_in_range   = res_q.cms_in_range;
  assign out_ch.battery_low    = res_q.battery_low;
  assign out_ch.mark_two       = res_q.mark_two;
  assign out_ch.speed_mode     = res_q.speed_mode;
  assign out_ch.error_code     = res_q.error_code;
  assign out_ch.frame_end      = res_q.frame_end;

endmodule
